>>> rtl/core/ssch_pkg.sv
// ----------------------------------------------------------------------------
// ssch_pkg - shared types and constants of the stride scheduler
// operation and status codes, slot record, controller states and the
// command and status groups between controller and datapath
// ----------------------------------------------------------------------------
package ssch_pkg;

	localparam int PRIO_W = 16;
	localparam int QNT_W  = 16;
	localparam int DONE_W = 16;
	localparam int ID_W   = 7;
	localparam int PROD_W = DONE_W + 1 + PRIO_W;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_TICK  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_BAD   = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// one table entry as held in the slot memory
	typedef struct packed {
		logic [DONE_W-1:0] done;
		logic [QNT_W-1:0]  quanta;
		logic [PRIO_W-1:0] prio;
	} slot_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_UPDATE,
		S_DONE
	} fsm_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic scan_step;
		logic update;
		logic load_out;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
		logic out_free;
	} dp_status_t;

endpackage

>>> rtl/core/ssch_ram.sv
// ----------------------------------------------------------------------------
// ssch_ram - generic single write, single read memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module ssch_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/ssch_ctrl.sv
// ----------------------------------------------------------------------------
// ssch_ctrl - stride scheduler controller
// sequences accept, slot scan, slot update and result hand-off
// ----------------------------------------------------------------------------
module ssch_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           operation,
	input  ssch_pkg::dp_status_t dp_status,
	output ssch_pkg::ctrl_cmd_t  cmd
);

	ssch_pkg::fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssch_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		in_ready      = 1'b0;
		unique case (state_q)
			ssch_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (ssch_pkg::op_t'(operation) == ssch_pkg::OP_TICK) begin
						state_d = ssch_pkg::S_SCAN;
					end else begin
						state_d = ssch_pkg::S_DONE;
					end
				end
			end
			ssch_pkg::S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (dp_status.scan_last) begin
					state_d = ssch_pkg::S_DRAIN;
				end
			end
			// last read data is compared here
			ssch_pkg::S_DRAIN: begin
				state_d = ssch_pkg::S_UPDATE;
			end
			ssch_pkg::S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ssch_pkg::S_DONE;
			end
			ssch_pkg::S_DONE: begin
				if (dp_status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ssch_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ssch_pkg::S_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/core/ssch_dp.sv
// ----------------------------------------------------------------------------
// ssch_dp - stride scheduler datapath
// slot memory, live flags, scan comparator, result and output registers
// ----------------------------------------------------------------------------
module ssch_dp #(
	parameter int MAX_PROCS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ssch_pkg::ctrl_cmd_t           cmd,
	output ssch_pkg::dp_status_t          dp_status,
	input  logic [1:0]                    operation,
	input  logic [ssch_pkg::PRIO_W-1:0]   priority_req,
	input  logic [ssch_pkg::QNT_W-1:0]    quanta,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ssch_pkg::ID_W-1:0]     out_id,
	output logic [1:0]                    out_status,
	output logic                          out_finished
);

	localparam int IDX_W = $clog2(MAX_PROCS);
	localparam int CNT_W = $clog2(MAX_PROCS + 1);
	localparam int PW    = ssch_pkg::PROD_W;

	// slot memory ports
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	ssch_pkg::slot_t      ram_wdata;
	ssch_pkg::slot_t      ram_rdata;

	logic [MAX_PROCS-1:0] live_q;
	logic [CNT_W-1:0]     loaded_q;

	logic [IDX_W-1:0]     rd_idx_q;
	logic                 rd_vld_s1;
	logic [IDX_W-1:0]     idx_s1;

	logic                          found_q;
	logic [IDX_W-1:0]              best_idx_q;
	ssch_pkg::slot_t               best_q;

	logic [ssch_pkg::ID_W-1:0]     res_id_q;
	ssch_pkg::status_t             res_status_q;
	logic                          res_fin_q;

	logic                          add_ok;
	logic                          is_tick;
	logic [PW-1:0]                 lhs, rhs;
	logic                          runs_first;
	logic                          take;
	logic [ssch_pkg::DONE_W-1:0]   new_done;
	logic                          fin_now;

	ssch_ram #(
		.WIDTH ($bits(ssch_pkg::slot_t)),
		.DEPTH (MAX_PROCS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	assign is_tick = ssch_pkg::op_t'(operation) == ssch_pkg::OP_TICK;
	assign add_ok  = (ssch_pkg::op_t'(operation) == ssch_pkg::OP_ADD) &&
	                 (priority_req != '0) && (quanta != '0) &&
	                 (loaded_q < CNT_W'(MAX_PROCS));

	// exact pass compare: (done_c+1)*prio_b against (done_b+1)*prio_c
	assign lhs        = (PW'(ram_rdata.done) + PW'(1)) * PW'(best_q.prio);
	assign rhs        = (PW'(best_q.done) + PW'(1)) * PW'(ram_rdata.prio);
	assign runs_first = (lhs < rhs) || ((lhs == rhs) && (ram_rdata.prio > best_q.prio));
	assign take       = rd_vld_s1 && live_q[idx_s1] && (!found_q || runs_first);

	assign new_done = best_q.done + ssch_pkg::DONE_W'(1);
	assign fin_now  = new_done >= best_q.quanta;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = best_idx_q;
		ram_wdata = '{done: new_done, quanta: best_q.quanta, prio: best_q.prio};
		if (cmd.accept && add_ok) begin
			ram_we    = 1'b1;
			ram_waddr = loaded_q[IDX_W-1:0];
			ram_wdata = '{done: '0, quanta: quanta, prio: priority_req};
		end else if (cmd.update && found_q) begin
			ram_we = 1'b1;
		end
	end

	assign dp_status.scan_last = rd_idx_q == IDX_W'(MAX_PROCS - 1);
	assign dp_status.out_free  = !out_valid || out_ready;

	// table bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q   <= '0;
			loaded_q <= '0;
		end else if (cmd.accept) begin
			if (ssch_pkg::op_t'(operation) == ssch_pkg::OP_CLEAR) begin
				live_q   <= '0;
				loaded_q <= '0;
			end else if (add_ok) begin
				live_q[loaded_q[IDX_W-1:0]] <= 1'b1;
				loaded_q                    <= loaded_q + CNT_W'(1);
			end
		end else if (cmd.update && found_q && fin_now) begin
			live_q[best_idx_q] <= 1'b0;
		end
	end

	// scan address and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_step;
			if (cmd.accept && is_tick) begin
				rd_idx_q <= '0;
				found_q  <= 1'b0;
			end else begin
				if (cmd.scan_step && !dp_status.scan_last) begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		if (take) begin
			best_idx_q <= idx_s1;
			best_q     <= ram_rdata;
		end
	end

	// result of the item in hand
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_id_q     <= '0;
			res_status_q <= ssch_pkg::ST_OK;
			res_fin_q    <= 1'b0;
		end else if (cmd.accept) begin
			res_id_q     <= '0;
			res_fin_q    <= 1'b0;
			res_status_q <= ssch_pkg::ST_OK;
			case (ssch_pkg::op_t'(operation)) inside
				ssch_pkg::OP_ADD: begin
					if (priority_req == '0 || quanta == '0) begin
						res_status_q <= ssch_pkg::ST_BAD;
					end else if (!add_ok) begin
						res_status_q <= ssch_pkg::ST_FULL;
					end else begin
						res_id_q <= ssch_pkg::ID_W'(loaded_q) + ssch_pkg::ID_W'(1);
					end
				end
				ssch_pkg::OP_TICK, ssch_pkg::OP_CLEAR: begin
					res_status_q <= ssch_pkg::ST_OK;
				end
				default: begin
					res_status_q <= ssch_pkg::ST_BAD;
				end
			endcase
		end else if (cmd.update) begin
			if (found_q) begin
				res_id_q     <= ssch_pkg::ID_W'(best_idx_q) + ssch_pkg::ID_W'(1);
				res_status_q <= ssch_pkg::ST_OK;
				res_fin_q    <= fin_now;
			end else begin
				res_id_q     <= '0;
				res_status_q <= ssch_pkg::ST_EMPTY;
				res_fin_q    <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_id       <= res_id_q;
			out_status   <= res_status_q;
			out_finished <= res_fin_q;
		end
	end

endmodule

>>> rtl/core/stride_scheduler.sv
// ----------------------------------------------------------------------------
// stride_scheduler - stride scheduler over a table of process slots
// add, tick and clear items in; one result item out per input item
// ----------------------------------------------------------------------------
//
//  channel   direction  tdata                           tuser
//  s_axis    in         [15:0] priority_req,            [1:0] operation
//                       [31:16] quanta
//  m_axis    out        [6:0] process_id, [8:7] status, -
//                       [9] finished, [15:10] zero
//
//  add, clear and unused codes go from accept straight to the result hand-off
//  a tick does one slot memory read and one cross-multiply compare per
//  slot, then writes back the winner
//  arst_n clears the live flags and the load count at once, no sweep
//  one item at a time; the next item is taken while the result waits
//  for m_axis_tready in the output register
//
module stride_scheduler #(
	parameter int MAX_PROCS = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // priority_req [15:0], quanta [31:16]
	input  logic [1:0]  s_axis_tuser,   // operation [1:0]

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // process_id [6:0], status [8:7], finished [9]
);

	ssch_pkg::ctrl_cmd_t  cmd;
	ssch_pkg::dp_status_t dp_status;

	logic [ssch_pkg::ID_W-1:0] out_id;
	logic [1:0]                out_status;
	logic                      out_finished;

	// sequencer: accept, scan over the slots, update, hand-off
	ssch_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.operation (s_axis_tuser),
		.dp_status (dp_status),
		.cmd       (cmd)
	);

	// slot table, comparator and output register
	ssch_dp #(
		.MAX_PROCS (MAX_PROCS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.dp_status    (dp_status),
		.operation    (s_axis_tuser),
		.priority_req (s_axis_tdata[15:0]),
		.quanta       (s_axis_tdata[31:16]),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_id       (out_id),
		.out_status   (out_status),
		.out_finished (out_finished)
	);

	// packed result item, zero padded to whole bytes
	assign m_axis_tdata = {6'b0, out_finished, out_status, out_id};

	// one item in hand at a time: no accept straight after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in hand");

	// a failing result (empty table, bad argument or table full) carries no id
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (out_status == ssch_pkg::ST_EMPTY || out_status == ssch_pkg::ST_BAD
		|| out_status == ssch_pkg::ST_FULL) |-> out_id == '0)
		else $error("id given with a failing status");

	// a finished process always comes with a good status and a real id
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_finished |-> out_status == ssch_pkg::ST_OK && out_id != '0)
		else $error("finished flag on a result with no process");

	// ids never go past the table size
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> out_id <= ssch_pkg::ID_W'(MAX_PROCS))
		else $error("process id beyond the table");

endmodule

>>> dv/stride_scheduler_test.sv
// ----------------------------------------------------------------------------
// stride_scheduler_test - self-checking bench for the stride scheduler
// drives add, tick and clear items into s_axis, tracks the process table
// alongside the block and checks every m_axis result field by field
// ----------------------------------------------------------------------------
module stride_scheduler_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PROCS   = 16;
	localparam int ITEMS       = 1750;
	localparam int STALL_LIMIT = 2000;
	// the code that means nothing to the block
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [ssch_pkg::ID_W-1:0] id;
		ssch_pkg::status_t         status;
		logic                      fin;
	} sched_result_t;

	// shadow of the process table, with the results it owes
	class proc_table #(int SLOTS = 16);
		logic [ssch_pkg::PRIO_W-1:0] prio_of [SLOTS];
		logic [ssch_pkg::QNT_W-1:0]  quanta_of [SLOTS];
		logic [ssch_pkg::DONE_W-1:0] done_of [SLOTS];
		bit                live [SLOTS];
		int unsigned       loaded = 0;
		sched_result_t     due_results [$];
		int errors = 0;
		int n_add = 0, n_tick = 0, n_fin = 0, n_full = 0, n_empty = 0, n_bad = 0, n_clear = 0;

		function void note_item(logic [1:0] op, logic [ssch_pkg::PRIO_W-1:0] prio,
				logic [ssch_pkg::QNT_W-1:0] qnt);
			sched_result_t r;
			int best;
			longint unsigned lhs, rhs;
			r.id = '0;
			r.status = ssch_pkg::ST_OK;
			r.fin = 1'b0;
			case (op)
				ssch_pkg::OP_ADD: begin
					if (prio == '0 || qnt == '0) begin
						r.status = ssch_pkg::ST_BAD;
						n_bad++;
					end else if (loaded >= SLOTS) begin
						r.status = ssch_pkg::ST_FULL;
						n_full++;
					end else begin
						prio_of[loaded] = prio;
						quanta_of[loaded] = qnt;
						done_of[loaded] = '0;
						live[loaded] = 1'b1;
						loaded++;
						r.id = ssch_pkg::ID_W'(loaded);
						n_add++;
					end
				end
				ssch_pkg::OP_TICK: begin
					best = -1;
					for (int i = 0; i < SLOTS; i++) begin
						if (!live[i])
							continue;
						if (best < 0) begin
							best = i;
						end else begin
							// exact pass compare, (done+1)/prio cross-multiplied
							lhs = (64'(done_of[i]) + 64'd1) * 64'(prio_of[best]);
							rhs = (64'(done_of[best]) + 64'd1) * 64'(prio_of[i]);
							// on equal pass the higher priority wins, else the lower id stays
							if (lhs < rhs || (lhs == rhs && prio_of[i] > prio_of[best]))
								best = i;
						end
					end
					if (best < 0) begin
						r.status = ssch_pkg::ST_EMPTY;
						n_empty++;
					end else begin
						r.id = ssch_pkg::ID_W'(best + 1);
						done_of[best] = done_of[best] + 1'b1;
						if (done_of[best] >= quanta_of[best]) begin
							live[best] = 1'b0;
							r.fin = 1'b1;
							n_fin++;
						end
						n_tick++;
					end
				end
				ssch_pkg::OP_CLEAR: begin
					foreach (live[i])
						live[i] = 1'b0;
					loaded = 0;
					n_clear++;
				end
				default: begin
					r.status = ssch_pkg::ST_BAD;
					n_bad++;
				end
			endcase
			due_results.push_back(r);
		endfunction

		function void check_result(logic [15:0] word);
			sched_result_t want;
			if (due_results.size() == 0) begin
				errors++;
				$display("%0t: result %h arrived with nothing expected", $time, word);
				return;
			end
			want = due_results.pop_front();
			if (word[6:0] != want.id) begin
				errors++;
				$display("%0t: process_id expected %0d, got %0d", $time, want.id, word[6:0]);
			end
			if (word[8:7] != want.status) begin
				errors++;
				$display("%0t: status expected %0d, got %0d", $time, want.status, word[8:7]);
			end
			if (word[9] != want.fin) begin
				errors++;
				$display("%0t: finished expected %0d, got %0d", $time, want.fin, word[9]);
			end
			if (word[15:10] != '0) begin
				errors++;
				$display("%0t: padding expected 0, got %h", $time, word[15:10]);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;     // priority_req [15:0], quanta [31:16]
	logic [1:0]  s_axis_tuser = '0;     // operation [1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;          // process_id [6:0], status [8:7], finished [9]

	proc_table #(MAX_PROCS) tbl;
	int items_sent = 0;
	bit idle_on    = 1'b1;   // random gaps allowed in this stretch
	bit quiet_tail = 1'b0;   // last part of the run, no gaps at all
	int stuck_cycles = 0;

	stride_scheduler #(.MAX_PROCS(MAX_PROCS)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// accepted items feed the shadow table, results are checked as they leave
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			tbl.note_item(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16]);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tbl.check_result(m_axis_tdata);
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles + 1 >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
				$display("tb: failure");
				$finish;
			end
		end
	end

	// result side back-pressure in short bursts
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (stall == 0 && idle_on && !quiet_tail && $urandom_range(0, 5) == 0)
				stall = $urandom_range(1, 3);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// entered and left just after a falling edge
	task automatic send_item(input logic [1:0] op, input logic [15:0] prio,
			input logic [15:0] qnt);
		int gap;
		if (idle_on && !quiet_tail && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 3);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {qnt, prio};
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	task automatic send_tick();
		send_item(ssch_pkg::OP_TICK, 16'($urandom), 16'($urandom));
	endtask

	// anything at all, zero arguments and the unused code included
	task automatic send_noise();
		logic [1:0] op;
		logic [15:0] prio, qnt;
		op   = 2'($urandom_range(0, 3));
		prio = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
		qnt  = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
		send_item(op, prio, qnt);
	endtask

	function automatic logic [15:0] pick_priority();
		case ($urandom_range(0, 9)) inside
			0:       return 16'hFFFF;
			1:       return 16'd1;
			2, 3, 4: return 16'($urandom_range(1, 4));   // small values give many ties
			5, 6:    return 16'($urandom_range(1, 255));
			default: return 16'($urandom_range(1, 65535));
		endcase
	endfunction

	function automatic logic [15:0] pick_quanta();
		case ($urandom_range(0, 9))
			7:       return 16'd1;
			8:       return 16'($urandom_range(1, 65535));
			9:       return 16'hFFFF;
			default: return 16'($urandom_range(1, 5));
		endcase
	endfunction

	task automatic run_directed();
		send_tick();                                           // empty table
		send_item(ssch_pkg::OP_ADD, 16'd0, 16'd7);             // zero priority
		send_item(ssch_pkg::OP_ADD, 16'd9, 16'd0);             // zero quanta
		send_item(ssch_pkg::OP_ADD, 16'd0, 16'd0);
		send_item(OP_UNUSED, 16'hFFFF, 16'hFFFF);
		// fill every slot, with equal priorities for id ties
		for (int i = 0; i < MAX_PROCS; i++) begin
			case (i % 4)
				0: send_item(ssch_pkg::OP_ADD, 16'hFFFF, 16'hFFFF);
				1: send_item(ssch_pkg::OP_ADD, 16'd1, 16'd1);
				2: send_item(ssch_pkg::OP_ADD, 16'h8000, 16'd2);
				default: send_item(ssch_pkg::OP_ADD, 16'(i), 16'd3);
			endcase
		end
		send_item(ssch_pkg::OP_ADD, 16'd5, 16'd5);             // table full
		send_item(ssch_pkg::OP_ADD, 16'd0, 16'd5);             // bad argument wins over full
		send_tick();
		send_tick();
		send_item(ssch_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF);
		send_tick();
	endtask

	initial begin
		int session;
		int n_procs;
		int n_ticks;
		tbl = new();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();

		// sessions: usually a clear, a batch of adds, then a random batch of ticks
		session = 0;
		while (items_sent < ITEMS) begin
			quiet_tail = (items_sent > ITEMS - 250);
			idle_on = ($urandom_range(0, 3) != 0);
			if (session % 20 == 5) begin
				// hold the sender until the block has caught up
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
				while (tbl.due_results.size() != 0)
					@(negedge clk);
			end
			if ($urandom_range(0, 3) != 0)
				send_item(ssch_pkg::OP_CLEAR, 16'($urandom), 16'($urandom));
			n_procs = ($urandom_range(0, 7) == 0) ? MAX_PROCS + 2 : $urandom_range(1, 12);
			for (int i = 0; i < n_procs; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_noise();
				send_item(ssch_pkg::OP_ADD, pick_priority(), pick_quanta());
			end
			n_ticks = $urandom_range(4, 40);
			for (int i = 0; i < n_ticks; i++) begin
				if ($urandom_range(0, 11) == 0)
					send_noise();
				send_tick();
			end
			session++;
		end
		s_axis_tvalid <= 1'b0;

		while (tbl.due_results.size() != 0)
			@(posedge clk);
		repeat (MAX_PROCS + 8) @(posedge clk);

		$display("covered %0d items over %0d sessions: %0d adds, %0d ticks, %0d finishes",
			items_sent, session, tbl.n_add, tbl.n_tick, tbl.n_fin);
		$display("  %0d clears, %0d full, %0d empty, %0d rejected; %0d mismatches",
			tbl.n_clear, tbl.n_full, tbl.n_empty, tbl.n_bad, tbl.errors);
		if (tbl.errors == 0 && tbl.due_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
